// ===== rtl/core/rpg_pkg.sv =====
// ----------------------------------------------------------------------------
// rpg_pkg: shared types and constants for the random permutation generator
// Sizes of the order table, the counters and the divider, the controller
// states, and the command and status bundles that pass between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package rpg_pkg;

	// table depth and derived widths
	localparam int ROWS   = 64;
	localparam int IDX_W  = $clog2(ROWS);
	localparam int CNT_W  = $clog2(ROWS + 1);
	localparam int REM_W  = CNT_W + 1;

	// fixed field widths
	localparam int SEED_W = 32;
	localparam int RCNT_W = 7;
	localparam int ROW_W  = 6;

	// divider: one dividend bit per cycle
	localparam int DIV_W  = SEED_W;
	localparam int BC_W   = $clog2(DIV_W);

	// xorshift32
	localparam logic [SEED_W-1:0] ZERO_SEED_SUB = 32'h9E37_79B9;
	localparam int XS_A = 13;
	localparam int XS_B = 17;
	localparam int XS_C = 5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL,
		ST_DRAW,
		ST_DIV,
		ST_SWAP_RD,
		ST_WR_TOP,
		ST_WR_J,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

	typedef struct packed {
		logic load;      // capture seed and count
		logic fill_wr;   // write identity entry, advance position
		logic pos_clr;   // return position to zero
		logic draw;      // advance xorshift, start a division
		logic div_step;  // one restoring division step
		logic swap_rd;   // read entries at top and partner
		logic wr_top;    // write partner value at top
		logic wr_j;      // write top value at partner, step i down
		logic emit_rd;   // read entry at position
		logic emit_ld;   // load output register, advance position
	} cmd_t;

	typedef struct packed {
		logic cnt_zero;      // item has no rows
		logic pos_last;      // position is at count-1
		logic shuf_done;     // i at or below one
		logic shuf_last;     // current swap is the final one
		logic div_last;      // division step is the final one
		logic out_free;      // output register can take a result
	} status_t;

	// one xorshift32 draw, zero word replaced
	function automatic logic [SEED_W-1:0] xorshift32(input logic [SEED_W-1:0] w);
		logic [SEED_W-1:0] x;
		x = (w == '0) ? ZERO_SEED_SUB : w;
		x = x ^ (x << XS_A);
		x = x ^ (x >> XS_B);
		x = x ^ (x << XS_C);
		return x;
	endfunction

endpackage

// ===== rtl/core/rpg_ctrl.sv =====
// ----------------------------------------------------------------------------
// rpg_ctrl: sequencer of the random permutation generator
// Steps the datapath through table fill, the shuffle (draw, divide, swap)
// and the emission of the shuffled order.
// ----------------------------------------------------------------------------
module rpg_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  rpg_pkg::status_t sts,
	output rpg_pkg::cmd_t    cmd
);
	import rpg_pkg::*;

	state_t state_q;
	state_t state_d;

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// decide next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_FILL;
				end
			end
			ST_FILL: begin
				if (sts.cnt_zero) begin
					state_d = ST_IDLE;
				end else begin
					cmd.fill_wr = 1'b1;
					if (sts.pos_last) begin
						cmd.pos_clr = 1'b1;
						state_d = sts.shuf_done ? ST_EMIT_RD : ST_DRAW;
					end
				end
			end
			ST_DRAW: begin
				cmd.draw = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_SWAP_RD;
				end
			end
			ST_SWAP_RD: begin
				cmd.swap_rd = 1'b1;
				state_d     = ST_WR_TOP;
			end
			ST_WR_TOP: begin
				cmd.wr_top = 1'b1;
				state_d    = ST_WR_J;
			end
			ST_WR_J: begin
				cmd.wr_j = 1'b1;
				state_d  = sts.shuf_last ? ST_EMIT_RD : ST_DRAW;
			end
			ST_EMIT_RD: begin
				cmd.emit_rd = 1'b1;
				state_d     = ST_EMIT_LD;
			end
			ST_EMIT_LD: begin
				if (sts.out_free) begin
					cmd.emit_ld = 1'b1;
					state_d = sts.pos_last ? ST_IDLE : ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/rpg_dpath.sv =====
// ----------------------------------------------------------------------------
// rpg_dpath: datapath of the random permutation generator
// Order table memory, xorshift32 word, bit-serial modulo unit, index
// counters and the output register.
// ----------------------------------------------------------------------------
module rpg_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [rpg_pkg::SEED_W-1:0]  seed,
	input  logic [rpg_pkg::RCNT_W-1:0]  row_count,
	input  rpg_pkg::cmd_t               cmd,
	output rpg_pkg::status_t            sts,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [rpg_pkg::ROW_W-1:0]   row_index,
	output logic                        last
);
	import rpg_pkg::*;

	logic [IDX_W-1:0]  mem [ROWS];

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  pos_q;
	logic [CNT_W-1:0]  i_q;
	logic [SEED_W-1:0] rng_q;
	logic [DIV_W-1:0]  dvd_q;
	logic [REM_W-1:0]  rem_q;
	logic [BC_W-1:0]   bit_cnt_q;
	logic [IDX_W-1:0]  rd_a_q;
	logic [IDX_W-1:0]  rd_b_q;
	logic [ROW_W-1:0]  row_q;
	logic              last_q;
	logic              out_valid_q;

	logic [CNT_W-1:0]  cnt_sat;
	logic [CNT_W-1:0]  top_w;
	logic [IDX_W-1:0]  top_idx;
	logic [IDX_W-1:0]  j_idx;
	logic [IDX_W-1:0]  pos_idx;
	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  rem_nx;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_wa;
	logic [IDX_W-1:0]  mem_wd;
	logic [IDX_W-1:0]  rd_a_addr;

	// saturate the row count at the table depth
	always_comb begin
		if ({{CNT_W{1'b0}}, row_count} > (CNT_W + RCNT_W)'(ROWS)) begin
			cnt_sat = CNT_W'(ROWS);
		end else begin
			cnt_sat = CNT_W'(row_count);
		end
	end

	// table addresses
	assign top_w   = CNT_W'(i_q - 1'b1);
	assign top_idx = top_w[IDX_W-1:0];
	assign j_idx   = rem_q[IDX_W-1:0];
	assign pos_idx = pos_q[IDX_W-1:0];

	// restoring division step: shift in next dividend bit, subtract if it fits
	assign rem_sh = {rem_q[REM_W-2:0], dvd_q[DIV_W-1]};
	assign rem_nx = (rem_sh >= REM_W'(i_q)) ? REM_W'(rem_sh - REM_W'(i_q)) : rem_sh;

	// status to the controller
	assign sts.cnt_zero  = (count_q == '0);
	assign sts.pos_last  = (pos_q == CNT_W'(count_q - 1'b1));
	assign sts.shuf_done = (i_q <= CNT_W'(1));
	assign sts.shuf_last = (i_q == CNT_W'(2));
	assign sts.div_last  = (bit_cnt_q == BC_W'(DIV_W - 1));
	assign sts.out_free  = !out_valid_q || !out_stall;

	// count, position and shuffle index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pos_q   <= '0;
			i_q     <= '0;
		end else begin
			if (cmd.load) begin
				count_q <= cnt_sat;
				i_q     <= cnt_sat;
				pos_q   <= '0;
			end else if (cmd.pos_clr) begin
				pos_q <= '0;
			end else if (cmd.fill_wr || cmd.emit_ld) begin
				pos_q <= CNT_W'(pos_q + 1'b1);
			end
			if (cmd.wr_j) begin
				i_q <= CNT_W'(i_q - 1'b1);
			end
		end
	end

	// random word and divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rng_q     <= '0;
			bit_cnt_q <= '0;
		end else begin
			if (cmd.load) begin
				rng_q <= seed;
			end else if (cmd.draw) begin
				rng_q     <= xorshift32(rng_q);
				bit_cnt_q <= '0;
			end else if (cmd.div_step) begin
				bit_cnt_q <= BC_W'(bit_cnt_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.draw) begin
			dvd_q <= xorshift32(rng_q);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
			rem_q <= rem_nx;
		end
	end

	// select the single table write
	always_comb begin
		mem_we = cmd.fill_wr || cmd.wr_top || cmd.wr_j;
		mem_wa = pos_idx;
		mem_wd = pos_idx;
		if (cmd.wr_top) begin
			mem_wa = top_idx;
			mem_wd = rd_b_q;
		end else if (cmd.wr_j) begin
			mem_wa = j_idx;
			mem_wd = rd_a_q;
		end
	end

	assign rd_a_addr = cmd.swap_rd ? top_idx : pos_idx;

	// order table: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (cmd.swap_rd || cmd.emit_rd) begin
			rd_a_q <= mem[rd_a_addr];
		end
		if (cmd.swap_rd) begin
			rd_b_q <= mem[j_idx];
		end
	end

	// output register: load on emit, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_ld) begin
			row_q  <= ROW_W'(rd_a_q);
			last_q <= sts.pos_last;
		end
	end

	assign out_valid = out_valid_q;
	assign row_index = row_q;
	assign last      = last_q;

endmodule

// ===== rtl/core/random_permutation_generator_unit.sv =====
// ----------------------------------------------------------------------------
// random_permutation_generator_unit: Fisher-Yates shuffle with xorshift32
// Takes a seed and a row count, emits a random permutation of 0..count-1.
// ----------------------------------------------------------------------------
// One item is handled at a time. An item of count n (saturated at 64) is
// accepted, the order table is filled with the identity, then each of the
// n-1 swaps takes one xorshift32 draw, the bit-serial modulo unit, one read of
// both entries and two writes on the table's single write port, and then each
// result is read through one of the table's registered read ports and loaded
// into the output register; the emission waits while the output stalls.
// A count of zero gives no results and frees the input once the controller
// leaves the fill state. The next item is accepted once the last result is
// loaded into the output register.
module random_permutation_generator_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [rpg_pkg::SEED_W-1:0]  seed,
	input  logic [rpg_pkg::RCNT_W-1:0]  row_count,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [rpg_pkg::ROW_W-1:0]   row_index,
	output logic                        last
);
	import rpg_pkg::*;

	cmd_t    cmd;
	status_t sts;

	// sequencer
	rpg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// table, random word, divider and output register
	rpg_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed      (seed),
		.row_count (row_count),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.row_index (row_index),
		.last      (last)
	);

endmodule
